// ===== src/sme_pkg.sv =====
// Shared types and constants for the eddy viscosity pipeline.
`default_nettype none
package sme_pkg;

    localparam int IDX_W      = 20;
    localparam int DIFF_W     = 24;
    localparam int INV_W      = 24;
    localparam int COEF_W     = 32;
    localparam int EV_W       = 32;
    // gradient product: 24b signed times 25b signed
    localparam int G_W        = 49;
    // strain rate, signed
    localparam int SR_W       = 36;
    // magnitude of a strain rate
    localparam int MAG_W      = 35;
    localparam int MAG_LO_W   = 18;
    localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
    localparam int SQ_W       = 69;
    localparam int SUM_W      = 74;
    localparam int ROOT_W     = 38;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 240;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_X = 8'd0,
        REG_INV_Y = 8'd1,
        REG_INV_Z = 8'd2,
        REG_COEF  = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [INV_W-1:0]  inv_x;
        logic [INV_W-1:0]  inv_y;
        logic [INV_W-1:0]  inv_z;
        logic [COEF_W-1:0] coef;
    } cfg_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] w_z;
        logic signed [DIFF_W-1:0] w_y;
        logic signed [DIFF_W-1:0] w_x;
        logic signed [DIFF_W-1:0] v_z;
        logic signed [DIFF_W-1:0] v_y;
        logic signed [DIFF_W-1:0] v_x;
        logic signed [DIFF_W-1:0] u_z;
        logic signed [DIFF_W-1:0] u_y;
        logic signed [DIFF_W-1:0] u_x;
    } diff_set_t;

    // beat handed from cell to cell in the square root chain
    typedef struct packed {
        logic [SUM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [IDX_W-1:0]  idx;
    } sqrt_beat_t;

endpackage
`default_nettype wire

// ===== src/sme_strain.sv =====
// Gradient, strain rate, square and sum stages feeding the square root chain.
`default_nettype none
module sme_strain (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [sme_pkg::IDX_W-1:0] in_idx,
    input  wire sme_pkg::diff_set_t    in_diff,
    input  wire sme_pkg::cfg_t         cfg,
    output logic                       out_valid,
    output sme_pkg::sqrt_beat_t        out_beat
);
    localparam int GW  = sme_pkg::G_W;
    localparam int SW  = sme_pkg::SR_W;
    localparam int MW  = sme_pkg::MAG_W;
    localparam int LW  = sme_pkg::MAG_LO_W;
    localparam int HW  = sme_pkg::MAG_HI_W;
    localparam int QW  = sme_pkg::SQ_W;
    localparam int UW  = sme_pkg::SUM_W;
    localparam int IW  = sme_pkg::IDX_W;

    logic [4:0] v_reg;
    logic [IW-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;

    logic signed [GW-1:0] g_next [9];
    logic signed [GW-1:0] g_reg  [9];
    logic signed [SW-1:0] s_next [6];
    logic signed [SW-1:0] s_reg  [6];
    logic [2*HW-1:0]      hh_next [6];
    logic [HW+LW-1:0]     hl_next [6];
    logic [2*LW-1:0]      ll_next [6];
    logic [2*HW-1:0]      hh_reg  [6];
    logic [HW+LW-1:0]     hl_reg  [6];
    logic [2*LW-1:0]      ll_reg  [6];
    logic [QW-1:0]        sq_next [6];
    logic [QW-1:0]        sq_reg  [6];
    logic [UW-1:0]        sum_next;
    logic [UW-1:0]        sum_reg;

    // Scale each difference by its axis reciprocal spacing
    always_comb begin
        g_next[0] = $signed(in_diff.u_x) * $signed({1'b0, cfg.inv_x});
        g_next[1] = $signed(in_diff.u_y) * $signed({1'b0, cfg.inv_y});
        g_next[2] = $signed(in_diff.u_z) * $signed({1'b0, cfg.inv_z});
        g_next[3] = $signed(in_diff.v_x) * $signed({1'b0, cfg.inv_x});
        g_next[4] = $signed(in_diff.v_y) * $signed({1'b0, cfg.inv_y});
        g_next[5] = $signed(in_diff.v_z) * $signed({1'b0, cfg.inv_z});
        g_next[6] = $signed(in_diff.w_x) * $signed({1'b0, cfg.inv_x});
        g_next[7] = $signed(in_diff.w_y) * $signed({1'b0, cfg.inv_y});
        g_next[8] = $signed(in_diff.w_z) * $signed({1'b0, cfg.inv_z});
    end

    // Round half up into strain rates: diagonal then off-diagonal pairs
    always_comb begin
        logic signed [GW-1:0] d0, d1, d2;
        logic signed [GW:0]   o0, o1, o2;
        d0 = g_reg[0] + GW'(4096);
        d1 = g_reg[4] + GW'(4096);
        d2 = g_reg[8] + GW'(4096);
        o0 = {g_reg[1][GW-1], g_reg[1]} + {g_reg[3][GW-1], g_reg[3]} + (GW+1)'(8192);
        o1 = {g_reg[2][GW-1], g_reg[2]} + {g_reg[6][GW-1], g_reg[6]} + (GW+1)'(8192);
        o2 = {g_reg[5][GW-1], g_reg[5]} + {g_reg[7][GW-1], g_reg[7]} + (GW+1)'(8192);
        s_next[0] = d0[GW-1:13];
        s_next[1] = d1[GW-1:13];
        s_next[2] = d2[GW-1:13];
        s_next[3] = o0[GW:14];
        s_next[4] = o1[GW:14];
        s_next[5] = o2[GW:14];
    end

    // Split each magnitude into halves and form partial products
    always_comb begin
        logic [SW-1:0] neg;
        logic [MW-1:0] mag;
        for (int k = 0; k < 6; k++) begin
            neg = SW'(0) - s_reg[k];
            mag = s_reg[k][SW-1] ? neg[MW-1:0] : s_reg[k][MW-1:0];
            hh_next[k] = mag[MW-1:LW] * mag[MW-1:LW];
            hl_next[k] = mag[MW-1:LW] * mag[LW-1:0];
            ll_next[k] = mag[LW-1:0] * mag[LW-1:0];
        end
    end

    // Recombine partials into full squares
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            sq_next[k] = (QW'(hh_reg[k]) << (2 * LW)) + (QW'(hl_reg[k]) << (LW + 1))
                       + QW'(ll_reg[k]);
        end
    end

    // Weighted sum: twice the diagonal squares, four times the off-diagonal
    always_comb begin
        sum_next = ((UW'(sq_reg[0]) + UW'(sq_reg[1]) + UW'(sq_reg[2])) << 1)
                 + ((UW'(sq_reg[3]) + UW'(sq_reg[4]) + UW'(sq_reg[5])) << 2);
    end

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg    <= g_next;
            s_reg    <= s_next;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            sq_reg   <= sq_next;
            sum_reg  <= sum_next;
            idx1_reg <= in_idx;
            idx2_reg <= idx1_reg;
            idx3_reg <= idx2_reg;
            idx4_reg <= idx3_reg;
            idx5_reg <= idx4_reg;
        end
    end

    assign out_valid      = v_reg[4];
    assign out_beat.rem   = sum_reg;
    assign out_beat.root  = '0;
    assign out_beat.idx   = idx5_reg;

endmodule
`default_nettype wire

// ===== src/sme_sqrt_cell.sv =====
// One cell of the square root chain: decides one root bit per beat.
`default_nettype none
module sme_sqrt_cell #(
    parameter int BIT = 0
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire sme_pkg::sqrt_beat_t in_beat,
    output logic                     out_valid,
    output sme_pkg::sqrt_beat_t      out_beat
);
    localparam int RW = sme_pkg::ROOT_W;
    localparam int UW = sme_pkg::SUM_W;
    localparam int TW = 2 * RW + 2;

    logic                valid_reg;
    sme_pkg::sqrt_beat_t beat_reg, beat_next;
    logic [TW-1:0]       trial;
    logic                fits;

    // Trial growth of root squared when this bit is set
    always_comb begin
        trial = (TW'(in_beat.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        fits  = TW'(in_beat.rem) >= trial;
        beat_next = in_beat;
        if (fits) begin
            beat_next.rem  = in_beat.rem - trial[UW-1:0];
            beat_next.root = in_beat.root | (RW'(1) << BIT);
        end
    end

    // Hold valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Pass beat on to the next cell
    always_ff @(posedge aclk) begin
        if (en) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule
`default_nettype wire

// ===== src/sme_scale.sv =====
// Coefficient multiply, saturation and output register.
`default_nettype none
module sme_scale (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire sme_pkg::sqrt_beat_t         in_beat,
    input  wire logic [sme_pkg::COEF_W-1:0]  coef,
    output logic                             out_valid,
    output logic [sme_pkg::IDX_W-1:0]        out_idx,
    output logic [sme_pkg::EV_W-1:0]         out_ev,
    output logic                             out_sat
);
    localparam int CW = sme_pkg::COEF_W;
    localparam int RW = sme_pkg::ROOT_W;
    localparam int EW = sme_pkg::EV_W;
    localparam int PW = CW + RW;

    logic [1:0]              v_reg;
    logic [2*CW-1:0]         plo_reg;
    logic [CW+RW-CW-1:0]     phi_reg;
    logic [sme_pkg::IDX_W-1:0] idx_reg, oidx_reg;
    logic [EW-1:0]           ev_reg, ev_next;
    logic                    sat_reg, sat_next;
    logic [PW-1:0]           prod;

    // Combine partial products and clip
    always_comb begin
        prod     = PW'(plo_reg) + (PW'(phi_reg) << CW);
        sat_next = |prod[PW-1:EW+24];
        ev_next  = sat_next ? {EW{1'b1}} : prod[EW+23:24];
    end

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    // Split the root into low and high parts for the multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg  <= coef * in_beat.root[CW-1:0];
            phi_reg  <= coef * in_beat.root[RW-1:CW];
            idx_reg  <= in_beat.idx;
            ev_reg   <= ev_next;
            sat_reg  <= sat_next;
            oidx_reg <= idx_reg;
        end
    end

    assign out_valid = v_reg[1];
    assign out_idx   = oidx_reg;
    assign out_ev    = ev_reg;
    assign out_sat   = sat_reg;

endmodule
`default_nettype wire

// ===== src/smagorinsky_eddy_viscosity_top.sv =====
// Top level of the eddy viscosity pipeline.
//
//  channel  direction  handshake              payload
//  s_       in         s_tvalid / s_tready    s_tdata: index, nine differences
//  m_       out        m_tvalid / m_tready    m_tdata: index, viscosity; m_tuser: clip flag
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One cell enters per cycle while the output is not stalled; a result passes through
// 5 strain stages, 38 square root cells and 2 scale stages.
// The root chain, one cell per root bit, sets the latency.
// Reset clears valid flags and loads the register defaults; no clearing pass.
// A stalled output holds the whole pipeline, and s_tready drops with it.
`default_nettype none
module smagorinsky_eddy_viscosity_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // cell_index, diff_u_x, diff_u_y, diff_u_z, diff_v_x, diff_v_y, diff_v_z,
    // diff_w_x, diff_w_y, diff_w_z, zero pad
    input  wire logic [sme_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // result_index, eddy_viscosity, zero pad
    output logic [sme_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // saturated
    output logic [0:0]                            m_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sme_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int IW = sme_pkg::IDX_W;
    localparam int DW = sme_pkg::DIFF_W;
    localparam int RW = sme_pkg::ROOT_W;

    sme_pkg::cfg_t       cfg_reg;
    sme_pkg::diff_set_t  in_diff;
    logic                en;
    logic                chain_valid [RW+1];
    sme_pkg::sqrt_beat_t chain_beat  [RW+1];
    logic [IW-1:0]       res_idx;
    logic [sme_pkg::EV_W-1:0] res_ev;
    logic                res_sat;

    // Whole pipeline moves when the output register is free
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_x <= sme_pkg::INV_W'(4096);
            cfg_reg.inv_y <= sme_pkg::INV_W'(4096);
            cfg_reg.inv_z <= sme_pkg::INV_W'(4096);
            cfg_reg.coef  <= sme_pkg::COEF_W'(429497);
        end else if (cfg_valid) begin
            case (cfg_index)
                sme_pkg::REG_INV_X: cfg_reg.inv_x <= cfg_data[sme_pkg::INV_W-1:0];
                sme_pkg::REG_INV_Y: cfg_reg.inv_y <= cfg_data[sme_pkg::INV_W-1:0];
                sme_pkg::REG_INV_Z: cfg_reg.inv_z <= cfg_data[sme_pkg::INV_W-1:0];
                sme_pkg::REG_COEF:  cfg_reg.coef  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack input beat
    assign in_diff = s_tdata[IW + 9*DW - 1:IW];

    sme_strain u_strain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_idx    (s_tdata[IW-1:0]),
        .in_diff   (in_diff),
        .cfg       (cfg_reg),
        .out_valid (chain_valid[0]),
        .out_beat  (chain_beat[0])
    );

    // Square root chain, most significant bit first
    for (genvar c = 0; c < RW; c++) begin : g_cell
        sme_sqrt_cell #(
            .BIT (RW - 1 - c)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[c]),
            .in_beat   (chain_beat[c]),
            .out_valid (chain_valid[c+1]),
            .out_beat  (chain_beat[c+1])
        );
    end

    sme_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chain_valid[RW]),
        .in_beat   (chain_beat[RW]),
        .coef      (cfg_reg.coef),
        .out_valid (m_tvalid),
        .out_idx   (res_idx),
        .out_ev    (res_ev),
        .out_sat   (res_sat)
    );

    assign m_tdata    = {4'b0, res_ev, res_idx};
    assign m_tuser[0] = res_sat;

    // A clipped result is all ones
    a_sat_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_sat |-> res_ev == {sme_pkg::EV_W{1'b1}})
        else $error("clip flag without full-scale viscosity");

    // Zero coefficient gives zero, unclipped
    a_zero_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cfg_reg.coef == '0 |-> res_ev == '0 && !res_sat)
        else $error("nonzero viscosity with zero coefficient");

    // A beat leaving the root chain reaches the scale stage
    a_chain_out: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_valid[RW] && en |=> u_scale.v_reg[0])
        else $error("beat lost after root chain");

    // Output empties the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire

// ===== tb/smagorinsky_eddy_viscosity_top_test.sv =====
// Testbench for the eddy viscosity pipeline: streamed cells checked against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module smagorinsky_eddy_viscosity_top_test;

    typedef struct {
        logic [sme_pkg::IDX_W-1:0] idx;
        logic [sme_pkg::EV_W-1:0]  visc;
        logic                      sat;
    } visc_result_t;

    typedef struct {
        logic [sme_pkg::IDX_W-1:0]         idx;
        logic signed [sme_pkg::DIFF_W-1:0] d [9];
    } cell_t;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    // Scoreboard: holds the register copy and the queue of predicted viscosities.
    class visc_scoreboard;
        logic [sme_pkg::INV_W-1:0]  inv_x = 24'd4096, inv_y = 24'd4096, inv_z = 24'd4096;
        logic [sme_pkg::COEF_W-1:0] coef = 32'd429497;
        visc_result_t               pending [$];
        int                         errors = 0;

        function void write_reg(logic [sme_pkg::CFG_IDX_W-1:0] idx,
                                logic [sme_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sme_pkg::REG_INV_X: inv_x = val[sme_pkg::INV_W-1:0];
                sme_pkg::REG_INV_Y: inv_y = val[sme_pkg::INV_W-1:0];
                sme_pkg::REG_INV_Z: inv_z = val[sme_pkg::INV_W-1:0];
                sme_pkg::REG_COEF:  coef = val;
                default: ;
            endcase
        endfunction

        // Round half up: floor((x + 2^(s-1)) / 2^s), arithmetic shift floors.
        function logic signed [sme_pkg::SR_W-1:0] rnd(logic signed [63:0] x, int s);
            logic signed [63:0] v;
            v = x + (64'sd1 <<< (s - 1));
            return v >>> s;
        endfunction

        function visc_result_t predict(cell_t c);
            logic signed [63:0] g [9];
            logic signed [63:0] sr [6];
            logic [127:0] sum, p, t;
            logic [63:0] root, m;
            logic signed [63:0] rs [3];
            visc_result_t r;
            rs[0] = {40'd0, inv_x}; rs[1] = {40'd0, inv_y}; rs[2] = {40'd0, inv_z};
            for (int i = 0; i < 9; i++) g[i] = 64'(c.d[i]) * rs[i % 3];
            // order of d: u_x u_y u_z v_x v_y v_z w_x w_y w_z
            sr[0] = rnd(g[0], 13);
            sr[1] = rnd(g[4], 13);
            sr[2] = rnd(g[8], 13);
            sr[3] = rnd(g[1] + g[3], 14);
            sr[4] = rnd(g[2] + g[6], 14);
            sr[5] = rnd(g[5] + g[7], 14);
            sum = 0;
            for (int i = 0; i < 6; i++) begin
                m = sr[i] < 0 ? 64'(-sr[i]) : 64'(sr[i]);
                sum += (i < 3 ? 128'd2 : 128'd4) * ({64'd0, m} * {64'd0, m});
            end
            root = 0;
            for (int b = 37; b >= 0; b--) begin
                t = {64'd0, root | (64'd1 << b)};
                if (t * t <= sum) root = t[63:0];
            end
            p = {96'd0, coef} * {64'd0, root};
            p = p >> 24;
            r.idx = c.idx;
            r.sat = p > 128'hFFFFFFFF;
            r.visc = r.sat ? 32'hFFFFFFFF : p[31:0];
            return r;
        endfunction

        function void note_cell(cell_t c);
            pending.push_back(predict(c));
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [sme_pkg::IDX_W-1:0] idx, logic [sme_pkg::EV_W-1:0] visc,
                          logic sat);
            visc_result_t e;
            if (pending.size() == 0) begin
                report("unexpected beat, index", 64'(idx), 64'd0);
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx) report("result_index", 64'(idx), 64'(e.idx));
            if (visc !== e.visc) report("eddy_viscosity", 64'(visc), 64'(e.visc));
            if (sat !== e.sat) report("saturated", 64'(sat), 64'(e.sat));
        endtask
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready;
    logic [sme_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0;
    logic [sme_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 0, cfg_ready;
    logic [sme_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sme_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    visc_scoreboard sb = new();
    cell_t in_flight;
    int cycles = 0;
    bit stall_on = 0;

    smagorinsky_eddy_viscosity_top DUT (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // Bound the run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Note accepted cells and check result beats.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_cell(in_flight);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[sme_pkg::IDX_W-1:0],
                            m_tdata[sme_pkg::IDX_W +: sme_pkg::EV_W], m_tuser[0]);
    end

    // Receiver stall pattern: ready at random, with probability 0.6, while stalls are on; always ready otherwise.
    always @(negedge aclk) begin
        if (!stall_on) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 9) < 6);
    end

    task put_cell(cell_t c);
        logic [sme_pkg::IN_TDATA_W-1:0] packed_cell;
        packed_cell = '0;
        packed_cell[sme_pkg::IDX_W-1:0] = c.idx;
        for (int i = 0; i < 9; i++)
            packed_cell[sme_pkg::IDX_W + i*sme_pkg::DIFF_W +: sme_pkg::DIFF_W] = c.d[i];
        in_flight = c;
        s_tdata <= packed_cell;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task idle_gap(int n);
        s_tvalid <= 0;
        repeat (n) @(negedge aclk);
    endtask

    task wait_drained;
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task write_reg(logic [sme_pkg::CFG_IDX_W-1:0] idx, logic [sme_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    task set_regs(logic [23:0] ix, logic [23:0] iy, logic [23:0] iz, logic [31:0] cf);
        write_reg(sme_pkg::REG_INV_X, 32'(ix));
        write_reg(sme_pkg::REG_INV_Y, 32'(iy));
        write_reg(sme_pkg::REG_INV_Z, 32'(iz));
        write_reg(sme_pkg::REG_COEF, cf);
    endtask

    function cell_t rand_cell(int style);
        cell_t c;
        c.idx = sme_pkg::IDX_W'($urandom());
        for (int i = 0; i < 9; i++) begin
            case (style)
                0: c.d[i] = sme_pkg::DIFF_W'($urandom());
                1: c.d[i] = sme_pkg::DIFF_W'(int'($urandom_range(0, 1024)) - 512);
                2: c.d[i] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                default: c.d[i] = sme_pkg::DIFF_W'(int'($urandom_range(0, 200000)) - 100000);
            endcase
        end
        return c;
    endfunction

    // Random phase: bursts of cells with random gaps.
    task random_burst(int n, int style);
        int left;
        left = n;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && left > 0; k++, left--)
                put_cell(rand_cell($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : style));
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
        end
    endtask

    initial begin
        cell_t c;
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: zeros, extremes, each gradient alone, index extremes.
        c.idx = 0;
        foreach (c.d[i]) c.d[i] = '0;
        put_cell(c);
        c.idx = 20'hFFFFF;
        foreach (c.d[i]) c.d[i] = 24'h7FFFFF;
        put_cell(c);
        foreach (c.d[i]) c.d[i] = 24'h800000;
        put_cell(c);
        for (int i = 0; i < 9; i++) begin
            c.idx = sme_pkg::IDX_W'(i + 1);
            foreach (c.d[j]) c.d[j] = '0;
            c.d[i] = (i % 2) ? 24'h800000 : 24'h000100;
            put_cell(c);
        end
        // Saturating setting: top coefficient and spacings.
        wait_drained();
        set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
        c.idx = 20'h12345;
        foreach (c.d[i]) c.d[i] = 24'h7FFFFF;
        put_cell(c);
        c.d[0] = 24'h000001;
        put_cell(c);
        // Zero spacing on one axis, then zero coefficient.
        wait_drained();
        set_regs(24'd0, 24'd1, 24'd4096, 32'd429497);
        put_cell(rand_cell(0));
        put_cell(rand_cell(2));
        wait_drained();
        set_regs(24'd4096, 24'd8192, 24'd0, 32'd0);
        put_cell(rand_cell(0));
        put_cell(rand_cell(2));
        // Unmapped register index is ignored.
        wait_drained();
        write_reg(8'd200, 32'hDEADBEEF);
        put_cell(rand_cell(3));
        wait_drained();

        stall_on = 1;
        set_regs(24'd4096, 24'd4096, 24'd4096, 32'd429497);
        random_burst(250, 3);
        wait_drained();
        set_regs(24'($urandom()), 24'($urandom()), 24'($urandom()), $urandom());
        random_burst(250, 0);
        wait_drained();
        stall_on = 0;
        set_regs(24'hFFFFFF, 24'd1, 24'h001000, 32'hFFFFFFFF);
        random_burst(200, 1);
        wait_drained();
        stall_on = 1;
        set_regs(24'd1, 24'hFFFFFF, 24'hFFFFFF, 32'h08000000);
        random_burst(250, 3);
        wait_drained();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
